FILE: design/pnf_pkg.sv
package pnf_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = 12;
    localparam int CNT_W        = 13;
    localparam int COORD_W      = 17;
    localparam int VERTEX_W     = 2 * COORD_W;
    localparam int DIST_W       = 33;
    localparam int ARC_W        = 29;
    localparam int IN_DATA_W    = 80;
    localparam int OUT_DATA_W   = 96;

    // iterative divider: numerator, denominator and quotient widths
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = 36;
    localparam int DIV_Q_W   = 19;
    localparam int DIV_CNT_W = 5;

    // iterative square root
    localparam int SQ_IN_W   = 36;
    localparam int SQ_ROOT_W = 18;
    localparam int SQ_REM_W  = 20;
    localparam int SQ_CNT_W  = 5;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_LOAD_A,
        ST_FETCH_B,
        ST_LOAD_B,
        ST_MUL_D,
        ST_SUM,
        ST_CHECK,
        ST_SQRT_WT,
        ST_MUL_F,
        ST_DIVU_GO,
        ST_DIVU_WT,
        ST_DIVV_GO,
        ST_DIVV_WT,
        ST_DIVA_GO,
        ST_DIVA_WT,
        ST_MUL_E,
        ST_CMP,
        ST_NEXT,
        ST_FINISH
    } state_t;

endpackage

FILE: design/pnf_ram.sv
module pnf_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/pnf_div.sv
module pnf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pnf_pkg::DIV_NUM_W-1:0] num,
    input  logic [pnf_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [pnf_pkg::DIV_Q_W-1:0]   quo
);

    localparam int NW = pnf_pkg::DIV_NUM_W;
    localparam int DW = pnf_pkg::DIV_DEN_W;
    localparam int QW = pnf_pkg::DIV_Q_W;
    localparam int CW = pnf_pkg::DIV_CNT_W;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_new;

    // one quotient bit per cycle, msb first
    assign rem_sh  = {rem_reg, lo_reg[QW-1]};
    assign diff    = rem_sh - {1'b0, den_reg};
    assign take    = !diff[DW];
    assign rem_new = take ? diff[DW-1:0] : rem_sh[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num >> QW);
            lo_reg  <= num[QW-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            lo_reg  <= {lo_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/pnf_sqrt.sv
module pnf_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pnf_pkg::SQ_IN_W-1:0]   radicand,
    output logic                          done,
    output logic [pnf_pkg::SQ_ROOT_W-1:0] root
);

    localparam int XW = pnf_pkg::SQ_IN_W;
    localparam int RW = pnf_pkg::SQ_ROOT_W;
    localparam int MW = pnf_pkg::SQ_REM_W;
    localparam int CW = pnf_pkg::SQ_CNT_W;

    logic [XW-1:0] x_reg;
    logic [MW-1:0] rem_reg;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [MW+1:0] rem_sh;
    logic [MW+1:0] trial;
    logic          take;
    logic [MW+1:0] diff;

    // two radicand bits per step, one root bit
    assign rem_sh = {rem_reg, x_reg[XW-1 -: 2]};
    assign trial  = (MW+2)'({r_reg, 2'b01});
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            rem_reg <= '0;
            r_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                x_reg   <= {x_reg[XW-3:0], 2'b00};
                rem_reg <= take ? diff[MW-1:0] : rem_sh[MW-1:0];
                r_reg   <= {r_reg[RW-2:0], take};
            end
            else
            begin
                // round to nearest: remainder above root means past the midpoint
                root_reg <= (rem_reg > MW'(r_reg)) ? r_reg + 1'b1 : r_reg;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: design/polyline_nearest_foot.sv
// a load item is written at its accepting edge and gives no result; a query result is
// registered once all segments are done (count capped at 4096, no segment below two
// vertices): per segment a memory read, for nonzero length an 18-step square root and,
// if the foot lies on the segment, three 19-step divisions; input is taken again next cycle
// reset: rst_n asynchronous active low clears vertex_count, the sequencer and
// the output valid flag; the vertex memory and the output data are not cleared
module polyline_nearest_foot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pnf_pkg::CNT_W-1:0]      cfg_data,   // vertex_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_index, coord_u, coord_v, dist_limit
    input  logic [pnf_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,    // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_u, point_v, arc_pos, best_dist
    output logic [pnf_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                     m_tuser     // found
);

    localparam int AW = pnf_pkg::ADDR_W;
    localparam int CW = pnf_pkg::CNT_W;
    localparam int PW = pnf_pkg::COORD_W;
    localparam int DW = pnf_pkg::DIST_W;
    localparam int RW = pnf_pkg::ARC_W;

    pnf_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] seg_reg;
    logic          found_reg;
    logic          out_valid_reg;

    logic [PW-1:0] pu_reg, pv_reg;
    logic [DW-1:0] limit_reg;
    logic [PW-1:0] au_reg, av_reg, bu_reg, bv_reg;
    logic signed [35:0] sq_u_reg, sq_v_reg, pr_u_reg, pr_v_reg;
    logic [34:0]   l2_reg;
    logic signed [36:0] dot_reg;
    logic [17:0]   len_reg;
    logic [RW-1:0] seg_start_reg, arc_start_reg;
    logic [52:0]   m_u_reg, m_v_reg, m_a_reg;
    logic signed [19:0] fu_reg, fv_reg;
    logic [18:0]   off_reg;
    logic [35:0]   e_u_sq_reg, e_v_sq_reg;
    logic [35:0]   best_reg;
    logic [PW-1:0] best_u_reg, best_v_reg;
    logic [RW-1:0] arc_best_reg;
    logic [pnf_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic          out_found_reg;

    // input fields
    logic          in_func;
    logic [AW-1:0] in_index;
    logic [PW-1:0] in_u, in_v;
    logic [DW-1:0] in_limit;
    logic          in_fire;
    logic [CW-1:0] in_n;

    assign in_func  = s_tuser[0];
    assign in_index = s_tdata[11:0];
    assign in_u     = s_tdata[28:12];
    assign in_v     = s_tdata[45:29];
    assign in_limit = s_tdata[78:46];
    assign in_fire  = s_tvalid && s_tready;
    assign in_n     = (count_reg > CW'(pnf_pkg::MAX_VERTICES)) ?
                      CW'(pnf_pkg::MAX_VERTICES) : count_reg;

    // memory
    logic                         ram_we;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [pnf_pkg::VERTEX_W-1:0] ram_rdata;

    assign ram_we = in_fire && (in_func == pnf_pkg::FUNC_LOAD);

    pnf_ram #(
        .WIDTH(pnf_pkg::VERTEX_W),
        .DEPTH(pnf_pkg::MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index),
        .wdata ({in_v, in_u}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // arithmetic units
    logic                          sqrt_start, sqrt_done;
    logic [pnf_pkg::SQ_ROOT_W-1:0] sqrt_root;
    logic                          div_start, div_done;
    logic [pnf_pkg::DIV_NUM_W-1:0] div_num;
    logic [pnf_pkg::DIV_Q_W-1:0]   div_quo;

    pnf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (pnf_pkg::SQ_IN_W'(l2_reg)),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pnf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({l2_reg, 1'b0}),
        .done  (div_done),
        .quo   (div_quo)
    );

    // segment datapath
    logic signed [17:0] du, dv, du_neg, dv_neg, pa_u, pa_v;
    logic [16:0]        abs_du, abs_dv;
    logic [34:0]        dot_u;
    logic               in_range;
    logic [29:0]        arc_sum, arc_foot;
    logic [RW-1:0]      arc_start_sat, arc_foot_sat;
    logic signed [19:0] fu_new, fv_new, eu, ev;
    logic signed [39:0] eu_sq, ev_sq;
    logic [35:0]        dst;
    logic               unlimited;
    logic               keep;
    logic               out_load;

    assign du     = signed'({1'b0, bu_reg}) - signed'({1'b0, au_reg});
    assign dv     = signed'({1'b0, bv_reg}) - signed'({1'b0, av_reg});
    assign pa_u   = signed'({1'b0, pu_reg}) - signed'({1'b0, au_reg});
    assign pa_v   = signed'({1'b0, pv_reg}) - signed'({1'b0, av_reg});
    assign du_neg = -du;
    assign dv_neg = -dv;
    assign abs_du = du[17] ? du_neg[16:0] : du[16:0];
    assign abs_dv = dv[17] ? dv_neg[16:0] : dv[16:0];

    assign dot_u    = dot_reg[34:0];
    assign in_range = !dot_reg[36] && (dot_reg[35:0] <= {1'b0, l2_reg});

    assign arc_sum       = {1'b0, arc_start_reg} + 30'(sqrt_root);
    assign arc_start_sat = arc_sum[RW] ? '1 : arc_sum[RW-1:0];
    assign arc_foot      = {1'b0, seg_start_reg} + 30'(off_reg);
    assign arc_foot_sat  = arc_foot[RW] ? '1 : arc_foot[RW-1:0];

    // foot moves toward b when the direction component is positive
    assign fu_new = du[17] ? signed'(20'({3'b000, au_reg})) - signed'(20'(div_quo))
                           : signed'(20'({3'b000, au_reg})) + signed'(20'(div_quo));
    assign fv_new = dv[17] ? signed'(20'({3'b000, av_reg})) - signed'(20'(div_quo))
                           : signed'(20'({3'b000, av_reg})) + signed'(20'(div_quo));
    assign eu     = signed'(20'({3'b000, pu_reg})) - fu_reg;
    assign ev     = signed'(20'({3'b000, pv_reg})) - fv_reg;
    assign eu_sq  = 40'(eu) * 40'(eu);
    assign ev_sq  = 40'(ev) * 40'(ev);
    assign dst    = e_u_sq_reg + e_v_sq_reg;

    assign unlimited = (limit_reg == '1);
    assign keep      = (unlimited && !found_reg) || (dst < best_reg);
    assign out_load  = (state_reg == pnf_pkg::ST_FINISH) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                if (in_fire && (in_func == pnf_pkg::FUNC_QUERY))
                begin
                    state_next = (in_n < CW'(2)) ? pnf_pkg::ST_FINISH : pnf_pkg::ST_FETCH_A;
                end
            end
            pnf_pkg::ST_FETCH_A: state_next = pnf_pkg::ST_LOAD_A;
            pnf_pkg::ST_LOAD_A:  state_next = pnf_pkg::ST_FETCH_B;
            pnf_pkg::ST_FETCH_B: state_next = pnf_pkg::ST_LOAD_B;
            pnf_pkg::ST_LOAD_B:  state_next = pnf_pkg::ST_MUL_D;
            pnf_pkg::ST_MUL_D:   state_next = pnf_pkg::ST_SUM;
            pnf_pkg::ST_SUM:     state_next = pnf_pkg::ST_CHECK;
            pnf_pkg::ST_CHECK:
            begin
                state_next = (l2_reg == '0) ? pnf_pkg::ST_NEXT : pnf_pkg::ST_SQRT_WT;
            end
            pnf_pkg::ST_SQRT_WT:
            begin
                if (sqrt_done)
                begin
                    state_next = in_range ? pnf_pkg::ST_MUL_F : pnf_pkg::ST_NEXT;
                end
            end
            pnf_pkg::ST_MUL_F:   state_next = pnf_pkg::ST_DIVU_GO;
            pnf_pkg::ST_DIVU_GO: state_next = pnf_pkg::ST_DIVU_WT;
            pnf_pkg::ST_DIVU_WT:
            begin
                if (div_done)
                begin
                    state_next = pnf_pkg::ST_DIVV_GO;
                end
            end
            pnf_pkg::ST_DIVV_GO: state_next = pnf_pkg::ST_DIVV_WT;
            pnf_pkg::ST_DIVV_WT:
            begin
                if (div_done)
                begin
                    state_next = pnf_pkg::ST_DIVA_GO;
                end
            end
            pnf_pkg::ST_DIVA_GO: state_next = pnf_pkg::ST_DIVA_WT;
            pnf_pkg::ST_DIVA_WT:
            begin
                if (div_done)
                begin
                    state_next = pnf_pkg::ST_MUL_E;
                end
            end
            pnf_pkg::ST_MUL_E:   state_next = pnf_pkg::ST_CMP;
            pnf_pkg::ST_CMP:     state_next = pnf_pkg::ST_NEXT;
            pnf_pkg::ST_NEXT:
            begin
                state_next = (seg_reg + 1'b1 == n_reg) ? pnf_pkg::ST_FINISH
                                                       : pnf_pkg::ST_FETCH_B;
            end
            pnf_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = pnf_pkg::ST_IDLE;
                end
            end
            default: state_next = pnf_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = (state_reg == pnf_pkg::ST_IDLE);
        ram_re     = 1'b0;
        ram_raddr  = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        unique case (state_reg)
            pnf_pkg::ST_FETCH_A:
            begin
                ram_re = 1'b1;
            end
            pnf_pkg::ST_FETCH_B:
            begin
                ram_re    = 1'b1;
                ram_raddr = seg_reg[AW-1:0];
            end
            pnf_pkg::ST_CHECK:
            begin
                sqrt_start = (l2_reg != '0);
            end
            pnf_pkg::ST_DIVU_GO:
            begin
                div_start = 1'b1;
                div_num   = pnf_pkg::DIV_NUM_W'({m_u_reg, 1'b0}) + pnf_pkg::DIV_NUM_W'(l2_reg);
            end
            pnf_pkg::ST_DIVV_GO:
            begin
                div_start = 1'b1;
                div_num   = pnf_pkg::DIV_NUM_W'({m_v_reg, 1'b0}) + pnf_pkg::DIV_NUM_W'(l2_reg);
            end
            pnf_pkg::ST_DIVA_GO:
            begin
                div_start = 1'b1;
                div_num   = pnf_pkg::DIV_NUM_W'({m_a_reg, 1'b0}) + pnf_pkg::DIV_NUM_W'(l2_reg);
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pnf_pkg::ST_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            seg_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == pnf_pkg::ST_IDLE && in_fire)
            begin
                found_reg <= 1'b0;
                n_reg     <= in_n;
                seg_reg   <= CW'(1);
            end
            if (state_reg == pnf_pkg::ST_CMP && keep)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == pnf_pkg::ST_NEXT)
            begin
                seg_reg <= seg_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                pu_reg        <= in_u;
                pv_reg        <= in_v;
                limit_reg     <= in_limit;
                best_reg      <= 36'(in_limit);
                best_u_reg    <= in_u;
                best_v_reg    <= in_v;
                arc_best_reg  <= '0;
                arc_start_reg <= '0;
            end
            pnf_pkg::ST_LOAD_A:
            begin
                au_reg <= ram_rdata[PW-1:0];
                av_reg <= ram_rdata[2*PW-1:PW];
            end
            pnf_pkg::ST_LOAD_B:
            begin
                bu_reg <= ram_rdata[PW-1:0];
                bv_reg <= ram_rdata[2*PW-1:PW];
            end
            pnf_pkg::ST_MUL_D:
            begin
                sq_u_reg <= 36'(du) * 36'(du);
                sq_v_reg <= 36'(dv) * 36'(dv);
                pr_u_reg <= 36'(pa_u) * 36'(du);
                pr_v_reg <= 36'(pa_v) * 36'(dv);
            end
            pnf_pkg::ST_SUM:
            begin
                l2_reg  <= sq_u_reg[34:0] + sq_v_reg[34:0];
                dot_reg <= 37'(pr_u_reg) + 37'(pr_v_reg);
            end
            pnf_pkg::ST_SQRT_WT:
            begin
                if (sqrt_done)
                begin
                    len_reg       <= sqrt_root;
                    seg_start_reg <= arc_start_reg;
                    arc_start_reg <= arc_start_sat;
                end
            end
            pnf_pkg::ST_MUL_F:
            begin
                m_u_reg <= 53'(dot_u) * 53'(abs_du);
                m_v_reg <= 53'(dot_u) * 53'(abs_dv);
                m_a_reg <= 53'(dot_u) * 53'(len_reg);
            end
            pnf_pkg::ST_DIVU_WT:
            begin
                if (div_done)
                begin
                    fu_reg <= fu_new;
                end
            end
            pnf_pkg::ST_DIVV_WT:
            begin
                if (div_done)
                begin
                    fv_reg <= fv_new;
                end
            end
            pnf_pkg::ST_DIVA_WT:
            begin
                if (div_done)
                begin
                    off_reg <= div_quo;
                end
            end
            pnf_pkg::ST_MUL_E:
            begin
                e_u_sq_reg <= eu_sq[35:0];
                e_v_sq_reg <= ev_sq[35:0];
            end
            pnf_pkg::ST_CMP:
            begin
                if (keep)
                begin
                    best_reg     <= dst;
                    best_u_reg   <= fu_reg[PW-1:0];
                    best_v_reg   <= fv_reg[PW-1:0];
                    arc_best_reg <= arc_foot_sat;
                end
            end
            pnf_pkg::ST_NEXT:
            begin
                au_reg <= bu_reg;
                av_reg <= bv_reg;
            end
            pnf_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    out_found_reg <= found_reg;
                    out_data_reg  <= {(best_reg[35:DW] != '0) ? {DW{1'b1}} : best_reg[DW-1:0],
                                      arc_best_reg, best_v_reg, best_u_reg};
                end
            end
            default:
            begin
                off_reg <= off_reg;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_found_reg;

endmodule
